/* rtl/core/nqse_pkg.sv */
// ----------------------------------------------------------------------------
// nqse_pkg
// shared types and constants of the n-queens enumerator
// ----------------------------------------------------------------------------
package nqse_pkg;

    localparam int MAX_QUEENS = 16;                       // largest board side
    localparam int ROW_W      = $clog2(MAX_QUEENS);       // row index / stored column
    localparam int COL_W      = $clog2(MAX_QUEENS + 1);   // column candidate, board side
    localparam int BS_W       = 5;                        // board_size register width
    localparam int FIELD_W    = 4;                        // packed column field width
    localparam int PLACE_W    = 64;                       // placement width
    localparam int CNT_W      = 24;                       // solution counter width
    localparam int IN_DATA_W  = 8;                        // input tdata width
    localparam int OUT_DATA_W = PLACE_W + CNT_W;          // output tdata width

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [BS_W-1:0]  BS_RESET  = BS_W'(8);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic cfg_we;
        logic start;
        logic step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic immediate;
        logic finish;
        logic out_free;
    } status_t;

endpackage

/* rtl/core/nqse_ctrl.sv */
// ----------------------------------------------------------------------------
// nqse_ctrl
// sequencer: accept a request, run the search steps, hand off the result
// ----------------------------------------------------------------------------
module nqse_ctrl
    import nqse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!cfg_valid && in_valid)
                begin
                    state_next = status.immediate ? S_EMIT : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.finish)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // config has priority over a request in the same cycle
                cfg_ready    = 1'b1;
                in_ready     = !cfg_valid;
                cmd.cfg_we   = cfg_valid;
                cmd.start    = !cfg_valid && in_valid;
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            S_EMIT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/nqse_dp.sv */
// ----------------------------------------------------------------------------
// nqse_dp
// board stack, conflict check, solution counter and output register
// ----------------------------------------------------------------------------
module nqse_dp
    import nqse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  restart,
    input  logic [BS_W-1:0]       cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_found,
    output logic [PLACE_W-1:0]    out_placement,
    output logic [CNT_W-1:0]      out_count
);

    logic [ROW_W-1:0] qc_reg [MAX_QUEENS];

    logic [BS_W-1:0]  board_size_reg, board_size_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             full_reg, full_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic               valid_reg, valid_next;
    logic               found_reg;
    logic [PLACE_W-1:0] place_reg;
    logic [CNT_W-1:0]   cnt_out_reg;

    logic [COL_W-1:0] side;
    logic [ROW_W-1:0] rd_idx;
    logic [COL_W-1:0] rd_col_inc;
    logic             full_eff;
    logic             done_eff;
    logic             col_over;
    logic             sq_free;
    logic             last_row;
    logic             qc_we;
    logic [PLACE_W-1:0] packed_place;

    assign side = (board_size_reg > BS_W'(MAX_QUEENS)) ? COL_W'(MAX_QUEENS)
                                                       : COL_W'(board_size_reg);

    // resume reads the last row; backtrack reads the row above
    assign rd_idx     = cmd.start ? row_reg : row_reg - ROW_W'(1);
    assign rd_col_inc = COL_W'(qc_reg[rd_idx]) + COL_W'(1);

    assign full_eff = restart ? 1'b0 : full_reg;
    assign done_eff = restart ? 1'b0 : done_reg;
    assign col_over = (col_reg >= side);
    assign last_row = ((COL_W'(row_reg) + COL_W'(1)) == side);

    // column and diagonal check against every placed row
    always_comb
    begin
        logic [COL_W-1:0] q;
        logic [COL_W-1:0] dc;
        sq_free = 1'b1;
        for (int i = 0; i < MAX_QUEENS; i++)
        begin
            q  = COL_W'(qc_reg[i]);
            dc = (q > col_reg) ? (q - col_reg) : (col_reg - q);
            if (ROW_W'(i) < row_reg)
            begin
                if ((q == col_reg) || (dc == (COL_W'(row_reg) - COL_W'(i))))
                begin
                    sq_free = 1'b0;
                end
            end
        end
    end

    assign qc_we = cmd.step && !col_over && sq_free;

    assign status.immediate = done_eff || (side == '0);
    assign status.finish    = (col_over && (row_reg == '0)) || qc_we && last_row;
    assign status.out_free  = !valid_reg || out_ready;

    always_comb
    begin
        board_size_next = board_size_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        full_next       = full_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        if (cmd.cfg_we)
        begin
            board_size_next = cfg_data;
            row_next        = '0;
            col_next        = '0;
            full_next       = 1'b0;
            done_next       = 1'b0;
            count_next      = '0;
        end
        else if (cmd.start)
        begin
            full_next  = full_eff;
            done_next  = done_eff;
            count_next = restart ? '0 : count_reg;
            if (done_eff)
            begin
                done_next = 1'b1;
            end
            else if (side == '0)
            begin
                done_next = 1'b1;
                full_next = 1'b0;
            end
            else if (full_eff)
            begin
                // row_reg still points at the last row of the previous solution
                col_next = rd_col_inc;
            end
            else
            begin
                row_next = '0;
                col_next = '0;
            end
        end
        else if (cmd.step)
        begin
            if (col_over)
            begin
                if (row_reg == '0)
                begin
                    done_next = 1'b1;
                    full_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg - ROW_W'(1);
                    col_next = rd_col_inc;
                end
            end
            else if (sq_free)
            begin
                if (last_row)
                begin
                    full_next = 1'b1;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    col_next = '0;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        packed_place = '0;
        for (int i = 0; i < MAX_QUEENS; i++)
        begin
            if ((COL_W'(i) < side) && !done_reg)
            begin
                packed_place[i*FIELD_W +: FIELD_W] = FIELD_W'(qc_reg[i]);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_size_reg <= BS_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            full_reg       <= 1'b0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            board_size_reg <= board_size_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            full_reg       <= full_next;
            done_reg       <= done_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qc_we)
        begin
            qc_reg[row_reg] <= col_reg[ROW_W-1:0];
        end
        if (cmd.load_out)
        begin
            found_reg   <= !done_reg;
            place_reg   <= packed_place;
            cnt_out_reg <= count_reg;
        end
    end

    assign out_valid     = valid_reg;
    assign out_found     = found_reg;
    assign out_placement = place_reg;
    assign out_count     = cnt_out_reg;

endmodule

/* rtl/core/n_queens_solution_enumerator.sv */
// a request that ends at once (search exhausted or empty board) goes from idle straight to emit;
// otherwise the search runs one step per square tried or backtrack since the last solution, then emits
// throughput: one request at a time; the combinational conflict check sets the pace
// the output register lets the next request start while a result waits
// reset: board_size returns to 8, search cleared, solution count zero, no result pending
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// depth-first n-queens search that returns one solution per request
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator
    import nqse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,    // [0] restart, [7:1] zero
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,    // [63:0] placement, [87:64] solution_number
    output logic [0:0]            m_tuser,    // [0] found
    // board size register
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [BS_W-1:0]       cfg_data
);

    cmd_t    cmd;
    status_t status;

    logic [PLACE_W-1:0] placement;
    logic [CNT_W-1:0]   solution_number;
    logic               found;

    // sequencer: idle -> search steps (skipped when a request ends at once) -> hand the result to the output register
    nqse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // row stack, conflict check, counter; each search step tries one square, backtracks one row or ends the search
    nqse_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .restart       (s_tdata[0]),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_found     (found),
        .out_placement (placement),
        .out_count     (solution_number)
    );

    // result transaction layout
    assign m_tdata    = {solution_number, placement};
    assign m_tuser[0] = found;

endmodule

/* rtl/core/nqse_checker.sv */
// ----------------------------------------------------------------------------
// nqse_checker
// port-level checks of the n-queens enumerator
// ----------------------------------------------------------------------------
module nqse_checker
    import nqse_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // exhaustion reports an empty placement
    a_empty_place: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[PLACE_W-1:0] == '0)
        else $error("exhausted result with nonzero placement");

    // a found solution has a nonzero running number
    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[OUT_DATA_W-1:PLACE_W] != '0)
        else $error("solution with zero count");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a search runs");

endmodule

bind n_queens_solution_enumerator nqse_checker u_nqse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
